// ----- rtl/mipmap_box_downsample_core_defines.svh -----
// Assertion macros for the mipmap box downsampler checker.
// Each macro takes a label, an antecedent and a consequent; all use clock and reset.
`ifndef MIPMAP_BOX_DOWNSAMPLE_CORE_DEFINES_SVH
`define MIPMAP_BOX_DOWNSAMPLE_CORE_DEFINES_SVH

// consequent must hold in the same cycle
`define MBD_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("mipmap box downsample check failed");

// consequent must hold in the next cycle
`define MBD_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("mipmap box downsample check failed");

`endif

// ----- rtl/mbd_pkg.sv -----
// Shared types and constants of the mipmap box downsampler.
// Used by mbd_ctrl, mbd_datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package mbd_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int DIM_W       = 13;
   localparam int COUNT_W     = 12;
   localparam int LINE_DEPTH  = MAX_WIDTH / 2;
   localparam int LINE_ADDR_W = $clog2(LINE_DEPTH);
   localparam int ROOT_STEPS  = 27;
   localparam int STEP_W      = 5;
   localparam int DIV_STEPS   = 17;
   localparam int ROOT_W      = 54;
   localparam int LEN_W       = 27;
   localparam int REM_W       = 28;
   localparam int Q_W         = 17;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_NORMAL_SELECT = 2'd2
   } csr_index_type;

   typedef logic [3:0][7:0] pixel_type;
   typedef logic [3:0][8:0] pair_type;
   typedef logic [3:0][9:0] total_type;

   typedef struct packed {
      logic                   accept;
      logic [LINE_ADDR_W-1:0] rd_addr;
      logic                   hold_write;
      logic                   line_write;
      logic [LINE_ADDR_W-1:0] wr_addr;
      logic                   sel_w1;
      logic                   sel_h1;
      logic                   tot_load;
      logic                   square;
      logic                   sum_load;
      logic                   root_step;
      logic [STEP_W-1:0]      root_k;
      logic                   div_load;
      logic                   div_step;
      logic                   out_load;
      logic                   out_single;
      logic                   out_normal;
      logic                   out_eor;
      logic                   out_eoi;
   } cmd_type;

   typedef struct packed {
      logic zero_vec;
   } status_type;

endpackage

// ----- rtl/mbd_ctrl.sv -----
// Controller of the mipmap box downsampler: configuration, raster position and sequencing.
// Depends on mbd_pkg; drives the command struct of mbd_datapath.
`timescale 1ns / 1ps

module mbd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [1:0]              csr_index,
   input  logic [mbd_pkg::DIM_W-1:0] csr_write_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  mbd_pkg::status_type     status,
   output mbd_pkg::cmd_type        cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAIR, ST_SQUARE, ST_SUM, ST_ROOT, ST_DIV_LOAD, ST_DIV, ST_FINISH
   } state_type;

   typedef struct packed {
      logic                            single;
      logic                            w1;
      logic                            h1;
      logic                            hold;
      logic                            even_row;
      logic                            eor;
      logic                            eoi;
      logic [mbd_pkg::LINE_ADDR_W-1:0] ox;
   } item_type;

   state_type                      state_ff, state_in;
   logic [mbd_pkg::DIM_W-1:0]      width_ff, width_in, height_ff, height_in;
   logic                           normal_ff, normal_in;
   logic [mbd_pkg::COUNT_W-1:0]    col_ff, col_in, row_ff, row_in;
   item_type                       item_ff, item_in;
   logic [mbd_pkg::STEP_W-1:0]     step_ff, step_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic [mbd_pkg::DIM_W-1:0]       w_eff, h_eff;
   logic                            w_one, h_one, accept, out_free;
   logic [mbd_pkg::LINE_ADDR_W-1:0] ox, oy;
   logic [mbd_pkg::COUNT_W-1:0]     ow, oh;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = mbd_pkg::DIM_W'(1);
      end else if (width_ff > mbd_pkg::DIM_W'(mbd_pkg::MAX_WIDTH)) begin
         w_eff = mbd_pkg::DIM_W'(mbd_pkg::MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = mbd_pkg::DIM_W'(1);
      end else if (height_ff > mbd_pkg::DIM_W'(mbd_pkg::MAX_HEIGHT)) begin
         h_eff = mbd_pkg::DIM_W'(mbd_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      w_one = (w_eff == mbd_pkg::DIM_W'(1));
      h_one = (h_eff == mbd_pkg::DIM_W'(1));
      ox    = w_one ? '0 : col_ff[mbd_pkg::COUNT_W-1:1];
      oy    = h_one ? '0 : row_ff[mbd_pkg::COUNT_W-1:1];
      ow    = (w_eff[mbd_pkg::DIM_W-1:1] == '0) ? mbd_pkg::COUNT_W'(1)
                                                 : w_eff[mbd_pkg::DIM_W-1:1];
      oh    = (h_eff[mbd_pkg::DIM_W-1:1] == '0) ? mbd_pkg::COUNT_W'(1)
                                                 : h_eff[mbd_pkg::DIM_W-1:1];
   end

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      normal_in    = normal_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      item_in      = item_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.rd_addr    = ox;
      cmd.wr_addr    = item_ff.ox;
      cmd.sel_w1     = item_ff.w1;
      cmd.sel_h1     = item_ff.h1;
      cmd.root_k     = step_ff;
      cmd.out_single = item_ff.single;
      cmd.out_normal = normal_ff && !item_ff.single;
      cmd.out_eor    = item_ff.eor;
      cmd.out_eoi    = item_ff.eoi;

      // config writes restart the level
      if (csr_write_enable) begin
         case (csr_index)
            mbd_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_write_data;
               col_in   = '0;
               row_in   = '0;
            end
            mbd_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_write_data;
               col_in    = '0;
               row_in    = '0;
            end
            mbd_pkg::CSR_NORMAL_SELECT: begin
               normal_in = csr_write_data[0];
               col_in    = '0;
               row_in    = '0;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accept       = 1'b1;
               item_in.single   = w_one && h_one;
               item_in.w1       = w_one;
               item_in.h1       = h_one;
               item_in.hold     = !w_one && !col_ff[0];
               item_in.even_row = !row_ff[0];
               item_in.ox       = ox;
               item_in.eor      = ({1'b0, ox} + mbd_pkg::COUNT_W'(1)) == ow;
               item_in.eoi      = item_in.eor
                                  && (({1'b0, oy} + mbd_pkg::COUNT_W'(1)) == oh);
               if ({1'b0, col_ff} + mbd_pkg::DIM_W'(1) >= w_eff) begin
                  col_in = '0;
                  row_in = ({1'b0, row_ff} + mbd_pkg::DIM_W'(1) >= h_eff)
                           ? '0 : row_ff + mbd_pkg::COUNT_W'(1);
               end else begin
                  col_in = col_ff + mbd_pkg::COUNT_W'(1);
               end
               state_in = ST_PAIR;
            end
         end
         ST_PAIR: begin
            if (item_ff.single) begin
               state_in = ST_FINISH;
            end else if (item_ff.hold) begin
               cmd.hold_write = 1'b1;
               state_in       = ST_IDLE;
            end else if (!item_ff.h1 && item_ff.even_row) begin
               cmd.line_write = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.tot_load = 1'b1;
               state_in     = normal_ff ? ST_SQUARE : ST_FINISH;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_load = 1'b1;
            step_in      = mbd_pkg::STEP_W'(mbd_pkg::ROOT_STEPS - 1);
            state_in     = status.zero_vec ? ST_FINISH : ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_DIV_LOAD;
            end else begin
               step_in = step_ff - mbd_pkg::STEP_W'(1);
            end
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = mbd_pkg::STEP_W'(mbd_pkg::DIV_STEPS - 1);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff - mbd_pkg::STEP_W'(1);
            end
         end
         ST_FINISH: begin
            // wait here while the previous result still sits in the output register
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= mbd_pkg::DIM_W'(1);
         height_ff    <= mbd_pkg::DIM_W'(1);
         normal_ff    <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         item_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         normal_ff    <= normal_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         item_ff      <= item_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/mbd_datapath.sv -----
// Datapath of the mipmap box downsampler: pair sums, line memory, bit-serial
// square root and divider lanes for normal maps, and the output register. Uses mbd_pkg.
`timescale 1ns / 1ps

module mbd_datapath (
   input  logic                clock,
   input  logic [7:0]          req_red,
   input  logic [7:0]          req_green,
   input  logic [7:0]          req_blue,
   input  logic [7:0]          req_alpha,
   input  mbd_pkg::cmd_type    cmd,
   output mbd_pkg::status_type status,
   output logic [7:0]          rsp_out_red,
   output logic [7:0]          rsp_out_green,
   output logic [7:0]          rsp_out_blue,
   output logic [7:0]          rsp_out_alpha,
   output logic                rsp_end_of_row,
   output logic                rsp_end_of_image
);

   mbd_pkg::pair_type   line_mem [mbd_pkg::LINE_DEPTH];

   mbd_pkg::pixel_type  pix_ff, held_ff;
   mbd_pkg::pair_type   rd_ff;
   mbd_pkg::total_type  tot_ff, tot_in;
   logic [2:0][19:0]    sq_ff;
   logic                zero_ff;
   logic [mbd_pkg::ROOT_W-1:0] v_ff, v_in, r_ff, r_in;
   logic [2:0][mbd_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [2:0][mbd_pkg::Q_W-1:0] q_ff, q_in;
   logic [3:0][7:0]     out_ff, out_in;
   logic                eor_ff, eoi_ff;

   mbd_pkg::pair_type   ps;
   logic [2:0][10:0]    c;
   logic [2:0]          neg;
   logic [2:0][9:0]     mag;
   logic [2:0][19:0]    sq;
   logic [21:0]         l2;
   logic [mbd_pkg::ROOT_W-1:0] b, rb;
   logic [mbd_pkg::LEN_W-1:0]  len;

   function automatic logic [7:0] norm_byte(input logic negative,
                                            input logic [mbd_pkg::Q_W-1:0] q);
      logic [17:0] x;
      logic [25:0] t;
      logic [26:0] o;
      x = negative ? (18'd65536 - 18'(q)) : (18'd65536 + 18'(q));
      t = 26'(x) * 26'd255;
      o = 27'(t) + 27'd65536;
      return (o[26:17] > 10'd255) ? 8'd255 : o[24:17];
   endfunction

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ps[i] = cmd.sel_w1 ? {pix_ff[i], 1'b0} : (9'(held_ff[i]) + 9'(pix_ff[i]));
         tot_in[i] = cmd.sel_h1 ? {ps[i], 1'b0} : (10'(rd_ff[i]) + 10'(ps[i]));
      end
      for (int i = 0; i < 3; i++) begin
         c[i]   = 11'({1'b0, tot_ff[i], 1'b0} - 12'd1020);
         neg[i] = c[i][10];
         mag[i] = neg[i] ? 10'(-c[i]) : c[i][9:0];
         sq[i]  = 20'(mag[i]) * 20'(mag[i]);
      end
      l2 = 22'(sq_ff[0]) + 22'(sq_ff[1]) + 22'(sq_ff[2]);
      status.zero_vec = (l2 == '0);

      // one digit of the root per step
      b  = mbd_pkg::ROOT_W'(1) << {cmd.root_k, 1'b0};
      rb = r_ff + b;
      if (v_ff >= rb) begin
         v_in = v_ff - rb;
         r_in = (r_ff >> 1) + b;
      end else begin
         v_in = v_ff;
         r_in = r_ff >> 1;
      end
      len = r_ff[mbd_pkg::LEN_W-1:0];

      // one quotient bit per step, three lanes
      for (int i = 0; i < 3; i++) begin
         if ({rem_ff[i][mbd_pkg::REM_W-2:0], 1'b0} >= mbd_pkg::REM_W'(len)) begin
            rem_in[i] = {rem_ff[i][mbd_pkg::REM_W-2:0], 1'b0} - mbd_pkg::REM_W'(len);
            q_in[i]   = {q_ff[i][mbd_pkg::Q_W-2:0], 1'b1};
         end else begin
            rem_in[i] = {rem_ff[i][mbd_pkg::REM_W-2:0], 1'b0};
            q_in[i]   = {q_ff[i][mbd_pkg::Q_W-2:0], 1'b0};
         end
      end

      for (int i = 0; i < 4; i++) begin
         out_in[i] = 8'((11'(tot_ff[i]) + 11'd2) >> 2);
      end
      if (cmd.out_normal) begin
         if (zero_ff) begin
            out_in[0] = 8'd128;
            out_in[1] = 8'd128;
            out_in[2] = 8'd255;
         end else begin
            for (int i = 0; i < 3; i++) begin
               out_in[i] = norm_byte(neg[i], q_ff[i]);
            end
         end
      end
      if (cmd.out_single) begin
         out_in = pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff <= {req_alpha, req_blue, req_green, req_red};
         rd_ff  <= line_mem[cmd.rd_addr];
      end
      if (cmd.hold_write) begin
         held_ff <= pix_ff;
      end
      if (cmd.line_write) begin
         line_mem[cmd.wr_addr] <= ps;
      end
      if (cmd.tot_load) begin
         tot_ff <= tot_in;
      end
      if (cmd.square) begin
         sq_ff <= sq;
      end
      if (cmd.sum_load) begin
         zero_ff <= status.zero_vec;
         v_ff    <= {l2, 32'd0};
         r_ff    <= '0;
      end
      if (cmd.root_step) begin
         v_ff <= v_in;
         r_ff <= r_in;
      end
      if (cmd.div_load) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[i] <= {3'd0, mag[i], 15'd0};
         end
         q_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
      if (cmd.out_load) begin
         out_ff <= out_in;
         eor_ff <= cmd.out_eor;
         eoi_ff <= cmd.out_eoi;
      end
   end

   assign rsp_out_red      = out_ff[0];
   assign rsp_out_green    = out_ff[1];
   assign rsp_out_blue     = out_ff[2];
   assign rsp_out_alpha    = out_ff[3];
   assign rsp_end_of_row   = eor_ff;
   assign rsp_end_of_image = eoi_ff;

endmodule

// ----- rtl/mipmap_box_downsample_core.sv -----
// Top level of the 2x2 box-filter mipmap downsampler for RGBA8 pixels.
// Joins mbd_ctrl and mbd_datapath; uses mbd_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   Write image_width (index 0), image_height (1) and the normal-map select (2) through
//   the csr_ port while the block is idle; each such write restarts the level at pixel 0.
//   Source pixels enter on req_ in raster order, one beat per pixel. A beat is taken
//   when req_valid is high and req_stall low; each filtered pixel leaves on rsp_ with
//   end_of_row and end_of_image flags.
//   Sequencing: a beat that completes no output passes through the pair state back to
//   idle. A plain-mode output is loaded in the finish state, which then returns to idle
//   to take the next beat. In normal-map mode the result runs through the 27-step
//   bit-serial square root and the 17-step divider lanes; a zero vector skips both.
//   req_stall stays high until the block is back in idle.
//   Every beat reads the line memory (2048 entries of pair sums) at its output column;
//   even source rows write it, odd rows read it back.
//   A finished result waits in the output register while rsp_stall is high; the next
//   beat is taken meanwhile, and only the following result waits for it to drain.
//   Reset (synchronous) sets a 1x1 plain-mode level, clears the position and drops
//   any pending result; req_stall is high during reset.

module mipmap_box_downsample_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [mbd_pkg::DIM_W-1:0] csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_red,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_blue,
   input  logic [7:0]                req_alpha,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_out_red,
   output logic [7:0]                rsp_out_green,
   output logic [7:0]                rsp_out_blue,
   output logic [7:0]                rsp_out_alpha,
   output logic                      rsp_end_of_row,
   output logic                      rsp_end_of_image
);

   mbd_pkg::cmd_type    cmd;
   mbd_pkg::status_type status;

   mbd_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .status           (status),
      .cmd              (cmd)
   );

   mbd_datapath u_datapath (
      .clock            (clock),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_alpha        (req_alpha),
      .cmd              (cmd),
      .status           (status),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_alpha    (rsp_out_alpha),
      .rsp_end_of_row   (rsp_end_of_row),
      .rsp_end_of_image (rsp_end_of_image)
   );

endmodule

// ----- rtl/mbd_checker.sv -----
// Port-level checker for mipmap_box_downsample_core, bound to the top level.
// Depends on the assertion macros of mipmap_box_downsample_core_defines.svh.
`timescale 1ns / 1ps
`include "mipmap_box_downsample_core_defines.svh"

module mbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_red,
   input logic       rsp_end_of_row,
   input logic       rsp_end_of_image
);

   `MBD_ASSERT_NEXT(a_rsp_hold_valid, rsp_valid && rsp_stall, rsp_valid)
   `MBD_ASSERT_NEXT(a_rsp_hold_red, rsp_valid && rsp_stall, $stable(rsp_out_red))
   `MBD_ASSERT_SAME(a_image_end_on_row_end, rsp_valid && rsp_end_of_image, rsp_end_of_row)
   `MBD_ASSERT_NEXT(a_busy_after_beat, req_valid && !req_stall, req_stall)

endmodule

bind mipmap_box_downsample_core mbd_checker u_mbd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_red      (rsp_out_red),
   .rsp_end_of_row   (rsp_end_of_row),
   .rsp_end_of_image (rsp_end_of_image)
);
